FILE: rtl/core/tcw_pkg.sv
// tcw_pkg: shared types, constants and register map of the congestion window controller
`default_nettype none

package tcw_pkg;

   localparam int WINDOW_BITS_DEF = 16;
   localparam int FIELD_BITS      = 16;
   localparam int CNT_BITS        = 16;
   localparam int SEQ_BITS        = 32;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CNT_BITS-1:0]   DUP_TRIGGER = 16'd3;
   localparam logic [CNT_BITS-1:0]   CNT_MAX     = 16'hFFFF;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX   = 16'hFFFF;
   localparam logic [SEQ_BITS-1:0]   SEQ_RESET   = 32'd1;

   localparam logic FUNC_ACK     = 1'b0;
   localparam logic FUNC_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      REG_INIT_WINDOW     = 2'd0,
      REG_INIT_THRESHOLD  = 2'd1,
      REG_THRESH_FROM_ADV = 2'd2,
      REG_INIT_ADV_WINDOW = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] initial_window;
      logic [FIELD_BITS-1:0] initial_threshold;
      logic                  threshold_from_advertised;
      logic [FIELD_BITS-1:0] initial_advertised_window;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      initial_window:            16'd1,
      initial_threshold:         16'hFFFF,
      threshold_from_advertised: 1'b0,
      initial_advertised_window: 16'hFFFF
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_APPLY,
      ST_AVOID,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic apply;
      logic step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic loop_pending;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_if.sv
// tcw_if: valid/ready channel interfaces for events and results
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [SEQ_BITS-1:0]   ack_seq;
   logic [FIELD_BITS-1:0] adv_window;
   logic                  window_update;

   modport source (output valid, output func, output ack_seq, output adv_window,
                   output window_update, input ready);
   modport sink   (input valid, input func, input ack_seq, input adv_window,
                   input window_update, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] send_window;
   logic                  fast_retransmit;
   logic [FIELD_BITS-1:0] cong_window;
   logic [FIELD_BITS-1:0] slow_start_threshold;

   modport source (output valid, output send_window, output fast_retransmit,
                   output cong_window, output slow_start_threshold, input ready);
   modport sink   (input valid, input send_window, input fast_retransmit,
                   input cong_window, input slow_start_threshold, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_csr.sv
// tcw_csr: apb register file holding the initial window settings
`default_nettype none

module tcw_csr import tcw_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg_next,
   output logic                          cfg_write
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;

   assign pready    = 1'b1;
   assign idx       = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_next  = cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (idx)
            REG_INIT_WINDOW:     cfg_in.initial_window = pwdata[FIELD_BITS-1:0];
            REG_INIT_THRESHOLD:  cfg_in.initial_threshold = pwdata[FIELD_BITS-1:0];
            REG_THRESH_FROM_ADV: cfg_in.threshold_from_advertised = pwdata[0];
            REG_INIT_ADV_WINDOW: cfg_in.initial_advertised_window = pwdata[FIELD_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_INIT_WINDOW:     prdata = CSR_DATA_BITS'(cfg_ff.initial_window);
         REG_INIT_THRESHOLD:  prdata = CSR_DATA_BITS'(cfg_ff.initial_threshold);
         REG_THRESH_FROM_ADV: prdata = CSR_DATA_BITS'(cfg_ff.threshold_from_advertised);
         REG_INIT_ADV_WINDOW: prdata = CSR_DATA_BITS'(cfg_ff.initial_advertised_window);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_dpath.sv
// tcw_dpath: congestion state registers, event update logic and avoidance step unit
`default_nettype none

module tcw_dpath import tcw_pkg::*; #(
   parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  cfg_type                    cfg_next,
   input  wire logic                  cfg_write,
   input  wire logic                  func,
   input  wire logic [SEQ_BITS-1:0]   ack_seq,
   input  wire logic [FIELD_BITS-1:0] adv_window,
   input  wire logic                  window_update,
   output logic      [FIELD_BITS-1:0] send_window,
   output logic                       fast_retransmit,
   output logic      [FIELD_BITS-1:0] cong_window,
   output logic      [FIELD_BITS-1:0] slow_start_threshold
);

   localparam int             W       = WINDOW_BITS;
   localparam int             GW      = SEQ_BITS + 1;
   localparam int             CW      = W + CNT_BITS;
   localparam logic [W-1:0]   WIN_MAX = '1;
   localparam logic [W-1:0]   WIN_ONE = W'(1);

   function automatic logic [W-1:0] win_clamp(input logic [FIELD_BITS-1:0] v);
      logic [CW-1:0] wide;
      wide = CW'(v);
      if (wide > CW'(WIN_MAX)) begin
         return WIN_MAX;
      end else if (v == '0) begin
         return WIN_ONE;
      end else begin
         return W'(v);
      end
   endfunction

   function automatic logic [FIELD_BITS-1:0] sat_field(input logic [W-1:0] v);
      if (CW'(v) > CW'(FIELD_MAX)) begin
         return FIELD_MAX;
      end else begin
         return FIELD_BITS'(v);
      end
   endfunction

   function automatic logic [W-1:0] init_threshold(input cfg_type c);
      if (c.threshold_from_advertised) begin
         return win_clamp(c.initial_advertised_window);
      end else begin
         return win_clamp(c.initial_threshold);
      end
   endfunction

   // latched event beat
   logic                  ev_func_ff;
   logic [SEQ_BITS-1:0]   ev_seq_ff;
   logic [FIELD_BITS-1:0] ev_adv_ff;
   logic                  ev_wu_ff;

   // values prepared in the prep state, ahead of the update
   logic [SEQ_BITS-1:0]   dist_ff,  dist_in;
   logic [CNT_BITS-1:0]   dup_ff,   dup_in;

   // congestion state
   logic [SEQ_BITS-1:0]   last_seq_ff,  last_seq_in;
   logic [CNT_BITS-1:0]   dup_count_ff, dup_count_in;
   logic                  recov_ff,     recov_in;
   logic [FIELD_BITS-1:0] peer_ff,      peer_in;
   logic [W-1:0]          cwnd_ff,      cwnd_in;
   logic [W-1:0]          thr_ff,       thr_in;
   logic [CNT_BITS-1:0]   avoid_ff,     avoid_in;
   logic                  avoid_on_ff,  avoid_on_in;
   logic                  fr_ff,        fr_in;

   logic [W-1:0]          half_thr;
   logic [GW-1:0]         grow_sum;
   logic [GW-1:0]         grow_excess;
   logic                  grow_over;
   logic [CNT_BITS-1:0]   c_grow;
   logic [GW-1:0]         avoid_sum;
   logic [CNT_BITS-1:0]   c_avoid;
   logic [CW-1:0]         avoid_wide;
   logic [CW-1:0]         cwnd_wide;
   logic [CW-1:0]         avoid_diff;
   logic                  loop_pending;
   logic                  cwnd_below_peer;

   // preparation: sequence distance and duplicate count
   always_comb begin
      dist_in = ev_seq_ff - last_seq_ff;
      if (ev_seq_ff == last_seq_ff) begin
         dup_in = (dup_count_ff == CNT_MAX) ? CNT_MAX : dup_count_ff + CNT_BITS'(1);
      end else begin
         dup_in = '0;
      end
      if (ev_wu_ff) begin
         dup_in = '0;
      end
   end

   assign half_thr = ((cwnd_ff >> 1) == '0) ? WIN_ONE : (cwnd_ff >> 1);

   // slow start that crosses the threshold hands the rest to avoidance
   assign grow_sum    = GW'(cwnd_ff) + GW'(dist_ff);
   assign grow_over   = grow_sum > GW'(thr_ff);
   assign grow_excess = grow_sum - GW'(thr_ff);
   assign c_grow      = (grow_excess > GW'(CNT_MAX)) ? CNT_MAX : grow_excess[CNT_BITS-1:0];

   assign avoid_sum = GW'(avoid_ff) + GW'(dist_ff);
   assign c_avoid   = (avoid_sum > GW'(CNT_MAX)) ? CNT_MAX : avoid_sum[CNT_BITS-1:0];

   // one avoidance iteration: subtract the window, grow it by one
   assign avoid_wide   = CW'(avoid_ff);
   assign cwnd_wide    = CW'(cwnd_ff);
   assign avoid_diff   = avoid_wide - cwnd_wide;
   assign loop_pending = avoid_on_ff && (avoid_wide >= cwnd_wide) && (cwnd_ff != WIN_MAX);
   assign status.loop_pending = loop_pending;

   always_comb begin
      last_seq_in  = last_seq_ff;
      dup_count_in = dup_count_ff;
      recov_in     = recov_ff;
      peer_in      = peer_ff;
      cwnd_in      = cwnd_ff;
      thr_in       = thr_ff;
      avoid_in     = avoid_ff;
      avoid_on_in  = avoid_on_ff;
      fr_in        = fr_ff;
      if (cfg_write) begin
         last_seq_in  = SEQ_RESET;
         dup_count_in = '0;
         recov_in     = 1'b0;
         peer_in      = cfg_next.initial_advertised_window;
         cwnd_in      = win_clamp(cfg_next.initial_window);
         thr_in       = init_threshold(cfg_next);
         avoid_in     = '0;
         avoid_on_in  = 1'b0;
      end else if (cmd.apply) begin
         avoid_on_in = 1'b0;
         fr_in       = 1'b0;
         if (ev_func_ff == FUNC_TIMEOUT) begin
            thr_in       = half_thr;
            cwnd_in      = win_clamp(cfg_next.initial_window);
            dup_count_in = '0;
            avoid_in     = '0;
            recov_in     = 1'b0;
         end else begin
            peer_in      = ev_adv_ff;
            dup_count_in = dup_ff;
            last_seq_in  = ev_seq_ff;
            if ((dup_ff > DUP_TRIGGER) && recov_ff) begin
               // window inflation while in recovery
               if (cwnd_ff != WIN_MAX) begin
                  cwnd_in = cwnd_ff + WIN_ONE;
               end
            end else if (dup_ff == DUP_TRIGGER) begin
               thr_in   = half_thr;
               recov_in = 1'b1;
               fr_in    = 1'b1;
            end else if ((dup_ff == '0) && recov_ff) begin
               cwnd_in  = thr_ff;
               recov_in = 1'b0;
               avoid_in = '0;
            end else if (dup_ff == '0) begin
               if (cwnd_ff < thr_ff) begin
                  if (grow_over) begin
                     cwnd_in     = thr_ff;
                     avoid_in    = c_grow;
                     avoid_on_in = 1'b1;
                  end else begin
                     cwnd_in = grow_sum[W-1:0];
                  end
               end else begin
                  avoid_in    = c_avoid;
                  avoid_on_in = 1'b1;
               end
            end
         end
      end else if (cmd.step && loop_pending) begin
         avoid_in = avoid_diff[CNT_BITS-1:0];
         cwnd_in  = cwnd_ff + WIN_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= SEQ_RESET;
         dup_count_ff <= '0;
         recov_ff     <= 1'b0;
         peer_ff      <= CFG_RESET.initial_advertised_window;
         cwnd_ff      <= win_clamp(CFG_RESET.initial_window);
         thr_ff       <= init_threshold(CFG_RESET);
         avoid_ff     <= '0;
         avoid_on_ff  <= 1'b0;
         fr_ff        <= 1'b0;
      end else begin
         last_seq_ff  <= last_seq_in;
         dup_count_ff <= dup_count_in;
         recov_ff     <= recov_in;
         peer_ff      <= peer_in;
         cwnd_ff      <= cwnd_in;
         thr_ff       <= thr_in;
         avoid_ff     <= avoid_in;
         avoid_on_ff  <= avoid_on_in;
         fr_ff        <= fr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ev_func_ff <= func;
         ev_seq_ff  <= ack_seq;
         ev_adv_ff  <= adv_window;
         ev_wu_ff   <= window_update;
      end
      if (cmd.prep) begin
         dist_ff <= dist_in;
         dup_ff  <= dup_in;
      end
   end

   // result beat register
   assign cwnd_below_peer = CW'(cwnd_ff) < CW'(peer_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         send_window          <= cwnd_below_peer ? FIELD_BITS'(cwnd_ff) : peer_ff;
         fast_retransmit      <= fr_ff;
         cong_window          <= sat_field(cwnd_ff);
         slow_start_threshold <= sat_field(thr_ff);
      end
   end

   a_cwnd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cwnd_ff != '0 && thr_ff != '0)
      else $error("congestion window or threshold reached zero");

   a_step_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && loop_pending && !cfg_write) |=> (cwnd_ff == $past(cwnd_ff) + WIN_ONE))
      else $error("avoidance step did not grow the window by one");

endmodule

`default_nettype wire

FILE: rtl/core/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine and result beat valid
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_AVOID;
         end
         ST_AVOID: begin
            if (status.loop_pending) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the previous result beat has left
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.load_out | (out_valid_ff & ~rsp_ready);
   assign rsp_valid    = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result register loaded while holding an untaken beat");

   a_idle_loop_done: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.loop_pending)
      else $error("ready for an event while avoidance work remains");

endmodule

`default_nettype wire

FILE: rtl/core/tcp_congestion_window_control.sv
// tcp_congestion_window_control: top level of the reno-style congestion window controller
// sequence: a taken event beat is captured, prepared and applied, then the avoidance
//   state runs one window subtract-and-increment per cycle for each congestion avoidance
//   iteration, then loads the result beat; the next event is taken while a result waits
// reset: synchronous; registers return to defaults and the congestion state is loaded
//   from them, and every register write re-initializes the congestion state the same way
`default_nettype none

module tcp_congestion_window_control import tcw_pkg::*; #(
   parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tcw_req_if.sink                       req_if,
   tcw_rsp_if.source                     rsp_if,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cmd_type    cmd;
   status_type status;
   cfg_type    cfg_next;
   logic       cfg_write;

   tcw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg_next  (cfg_next),
      .cfg_write (cfg_write)
   );

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tcw_dpath #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .cfg_next             (cfg_next),
      .cfg_write            (cfg_write),
      .func                 (req_if.func),
      .ack_seq              (req_if.ack_seq),
      .adv_window           (req_if.adv_window),
      .window_update        (req_if.window_update),
      .send_window          (rsp_if.send_window),
      .fast_retransmit      (rsp_if.fast_retransmit),
      .cong_window          (rsp_if.cong_window),
      .slow_start_threshold (rsp_if.slow_start_threshold)
   );

endmodule

`default_nettype wire

FILE: tb/tcp_congestion_window_control_tb.sv
// testbench for the congestion window controller: directed table, duplicate run, random phases
`default_nettype none

module tcp_congestion_window_control_tb;
   import tcw_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PCT        = 37;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 200;
   localparam int BURST_DUPS      = 40;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int QUIET_PHASE     = 3;
   localparam int PRESSURE_PHASE  = 4;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int NUM_DIRECTED    = 22;
   localparam int SETTLE_CYCLES   = 2;
   localparam int DRAIN_CYCLES    = 40;
   localparam longint unsigned WIN_MAX = (64'd1 << WINDOW_BITS_DEF) - 64'd1;

   typedef struct packed {
      logic                  func;
      logic [SEQ_BITS-1:0]   seq;
      logic [FIELD_BITS-1:0] adv;
      logic                  wu;
   } cc_event_t;

   typedef struct packed {
      logic [FIELD_BITS-1:0] send_window;
      logic                  fast_retransmit;
      logic [FIELD_BITS-1:0] cong_window;
      logic [FIELD_BITS-1:0] ssthresh;
   } window_result_t;

   typedef struct packed {
      cc_event_t      evt;
      logic           typed;
      window_result_t res;
   } directed_row_t;

   localparam logic           TYPED     = 1'b1;
   localparam logic           PREDICTED = 1'b0;
   localparam window_result_t NO_RES    = '0;

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   tcp_congestion_window_control uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted congestion state and register copy
   cfg_type               model_cfg;
   logic [SEQ_BITS-1:0]   m_last_seq;
   logic [CNT_BITS-1:0]   m_dup;
   logic                  m_recov;
   logic [FIELD_BITS-1:0] m_peer;
   logic [FIELD_BITS-1:0] m_cwnd;
   logic [FIELD_BITS-1:0] m_thr;
   logic [CNT_BITS-1:0]   m_avoid;

   window_result_t pending_windows [$];
   int             mismatches = 0;
   logic           quiet = 1'b0;
   logic           hold_pending = 1'b0;

   directed_row_t plan [NUM_DIRECTED] = '{
      // func, ack_seq, adv_window, window_update, typed, send, fr, cwnd, ssthresh
      {FUNC_ACK,     32'd1,          16'hFFFF, 1'b0, TYPED, 16'd1, 1'b0, 16'd1, 16'hFFFF},
      {FUNC_ACK,     32'd1,          16'hFFFF, 1'b0, TYPED, 16'd1, 1'b0, 16'd1, 16'hFFFF},
      {FUNC_ACK,     32'd1,          16'hFFFF, 1'b0, TYPED, 16'd1, 1'b1, 16'd1, 16'd1},
      {FUNC_ACK,     32'd1,          16'hFFFF, 1'b0, TYPED, 16'd2, 1'b0, 16'd2, 16'd1},
      {FUNC_ACK,     32'd1,          16'hFFFF, 1'b1, TYPED, 16'd1, 1'b0, 16'd1, 16'd1},
      {FUNC_ACK,     32'd11,         16'd100,  1'b0, PREDICTED, NO_RES},
      {FUNC_TIMEOUT, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, PREDICTED, NO_RES},
      {FUNC_ACK,     32'h0000_0010,  16'd0,    1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'hFFFF_FFFF,  16'hFFFF, 1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'hFFFF, 1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'd8,    1'b1, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'd0,    1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'd0,    1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'd0,    1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'hFFFF, 1'b0, PREDICTED, NO_RES},
      {FUNC_TIMEOUT, 32'd0,          16'd0,    1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd0,          16'h1234, 1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'd5,          16'hFFFF, 1'b1, PREDICTED, NO_RES},
      {FUNC_ACK,     32'h8000_0000,  16'h5555, 1'b0, PREDICTED, NO_RES},
      {FUNC_ACK,     32'h7FFF_FFFF,  16'hAAAA, 1'b0, PREDICTED, NO_RES},
      {FUNC_TIMEOUT, 32'h5555_5555,  16'h8000, 1'b0, PREDICTED, NO_RES},
      {FUNC_TIMEOUT, 32'hAAAA_AAAA,  16'h0001, 1'b1, PREDICTED, NO_RES}
   };

   cfg_type phase_cfg [NUM_PHASES] = '{
      {16'd0,    16'd0,    1'b0, 16'd0},
      {16'hFFFF, 16'd1,    1'b0, 16'hFFFF},
      {16'd10,   16'd40,   1'b1, 16'h0020},
      {16'd1,    16'hFFFF, 1'b1, 16'd0},
      {16'd1,    16'd1,    1'b0, 16'd1},
      {16'd4,    16'd16,   1'b0, 16'hFFFF}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [FIELD_BITS-1:0] at_least_one(input logic [FIELD_BITS-1:0] v);
      return (v == '0) ? FIELD_BITS'(1) : v;
   endfunction

   function automatic logic [FIELD_BITS-1:0] half_window();
      return at_least_one(m_cwnd >> 1);
   endfunction

   function automatic void load_state();
      m_last_seq = SEQ_RESET;
      m_dup      = '0;
      m_recov    = 1'b0;
      m_avoid    = '0;
      m_peer     = model_cfg.initial_advertised_window;
      m_cwnd     = at_least_one(model_cfg.initial_window);
      m_thr      = at_least_one(model_cfg.threshold_from_advertised ?
                                model_cfg.initial_advertised_window :
                                model_cfg.initial_threshold);
   endfunction

   // one window increment per cwnd worth of acknowledged datagrams
   function automatic void cong_avoid(input longint unsigned gap);
      longint unsigned c;
      c = 64'(m_avoid);
      c = c + gap;
      if (c > 64'(CNT_MAX)) c = 64'(CNT_MAX);
      while (c >= 64'(m_cwnd) && 64'(m_cwnd) < WIN_MAX) begin
         c      = c - 64'(m_cwnd);
         m_cwnd = m_cwnd + FIELD_BITS'(1);
      end
      m_avoid = c[CNT_BITS-1:0];
   endfunction

   function automatic window_result_t advance_window(input cc_event_t evt);
      window_result_t  res;
      logic [SEQ_BITS-1:0] seq_gap;
      longint unsigned step;
      longint unsigned used;
      res = '0;
      if (evt.func == FUNC_TIMEOUT) begin
         m_thr   = half_window();
         m_cwnd  = at_least_one(model_cfg.initial_window);
         m_dup   = '0;
         m_avoid = '0;
         m_recov = 1'b0;
      end else begin
         seq_gap = evt.seq - m_last_seq;
         step    = 64'(seq_gap);
         m_peer  = evt.adv;
         if (evt.seq == m_last_seq) begin
            if (m_dup != CNT_MAX) m_dup = m_dup + CNT_BITS'(1);
         end else begin
            m_dup = '0;
         end
         if (evt.wu) m_dup = '0;

         if (m_dup > DUP_TRIGGER && m_recov) begin
            if (64'(m_cwnd) < WIN_MAX) m_cwnd = m_cwnd + FIELD_BITS'(1);
         end else if (m_dup == DUP_TRIGGER) begin
            m_thr               = half_window();
            m_recov             = 1'b1;
            res.fast_retransmit = 1'b1;
         end else if (m_dup == '0 && m_recov) begin
            m_cwnd  = m_thr;
            m_recov = 1'b0;
            m_avoid = '0;
         end else if (m_dup == '0) begin
            if (m_cwnd < m_thr) begin
               // slow start, the part past the threshold goes to avoidance
               if (64'(m_cwnd) + step > 64'(m_thr)) begin
                  used    = 64'(m_thr) - 64'(m_cwnd);
                  m_cwnd  = m_thr;
                  m_avoid = '0;
                  cong_avoid(step - used);
               end else begin
                  m_cwnd = m_cwnd + step[FIELD_BITS-1:0];
               end
            end else begin
               cong_avoid(step);
            end
         end
         m_last_seq = evt.seq;
      end
      res.send_window = (m_cwnd < m_peer) ? m_cwnd : m_peer;
      res.cong_window = m_cwnd;
      res.ssthresh    = m_thr;
      return res;
   endfunction

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_INIT_WINDOW:     model_cfg.initial_window            = val[FIELD_BITS-1:0];
         REG_INIT_THRESHOLD:  model_cfg.initial_threshold         = val[FIELD_BITS-1:0];
         REG_THRESH_FROM_ADV: model_cfg.threshold_from_advertised = val[0];
         REG_INIT_ADV_WINDOW: model_cfg.initial_advertised_window = val[FIELD_BITS-1:0];
         default: ;
      endcase
      load_state();
   endtask

   // present one event beat and book its expected result when it is taken
   task automatic offer(input cc_event_t evt, input logic typed, input window_result_t res);
      window_result_t predicted;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (!quiet && $urandom_range(99) < IDLE_PCT);
      end
      req_ch.valid         <= 1'b1;
      req_ch.func          <= evt.func;
      req_ch.ack_seq       <= evt.seq;
      req_ch.adv_window    <= evt.adv;
      req_ch.window_update <= evt.wu;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_window(evt);
      pending_windows.push_back(typed ? res : predicted);
   endtask

   task automatic drain_results(input int extra);
      req_ch.valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side back-pressure, with one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : result_check
      window_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_windows.size() == 0) begin
            $display("%0t: result beat with nothing expected, send_window %0d", $time,
                     rsp_ch.send_window);
            mismatches++;
         end else begin
            want = pending_windows.pop_front();
            check_field("send_window", 32'(want.send_window), 32'(rsp_ch.send_window));
            check_field("fast_retransmit", 32'(want.fast_retransmit),
                        32'(rsp_ch.fast_retransmit));
            check_field("cong_window", 32'(want.cong_window), 32'(rsp_ch.cong_window));
            check_field("slow_start_threshold", 32'(want.ssthresh),
                        32'(rsp_ch.slow_start_threshold));
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL tcp_congestion_window_control");
            $finish;
         end
      end
   end

   initial begin
      cc_event_t evt;
      cfg_type   cfg;
      logic [SEQ_BITS-1:0] burst_seq;
      int r;
      int dup_left;
      dup_left = 0;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.func          <= FUNC_ACK;
      req_ch.ack_seq       <= '0;
      req_ch.adv_window    <= '0;
      req_ch.window_update <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      model_cfg = CFG_RESET;
      load_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) offer(plan[k].evt, plan[k].typed, plan[k].res);

      // duplicate run through fast retransmit and window inflation, then a new ack
      quiet     = 1'b1;
      burst_seq = m_last_seq + SEQ_BITS'(1);
      offer({FUNC_ACK, burst_seq, 16'hFFFF, 1'b0}, PREDICTED, NO_RES);
      for (int k = 0; k < BURST_DUPS; k++)
         offer({FUNC_ACK, burst_seq, 16'hFFFF, 1'b0}, PREDICTED, NO_RES);
      offer({FUNC_ACK, burst_seq + SEQ_BITS'(1), 16'hFFFF, 1'b0}, PREDICTED, NO_RES);
      quiet = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results(SETTLE_CYCLES);
         cfg = phase_cfg[p];
         if (p == PRESSURE_PHASE) begin
            cfg.initial_window            = FIELD_BITS'($urandom_range(1, 64));
            cfg.initial_threshold         = FIELD_BITS'($urandom_range(0, 65535));
            cfg.threshold_from_advertised = 1'($urandom_range(0, 1));
            cfg.initial_advertised_window = FIELD_BITS'($urandom_range(0, 65535));
         end
         csr_write(REG_INIT_WINDOW, {16'd0, cfg.initial_window});
         csr_write(REG_INIT_THRESHOLD, {16'd0, cfg.initial_threshold});
         csr_write(REG_THRESH_FROM_ADV, {31'd0, cfg.threshold_from_advertised});
         csr_write(REG_INIT_ADV_WINDOW, {16'd0, cfg.initial_advertised_window});
         quiet    = (p == QUIET_PHASE);
         dup_left = 0;
         if (p == PRESSURE_PHASE) hold_pending = 1'b1;

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // keep offering without gaps while the result side is held off
            if (p == PRESSURE_PHASE) quiet = (i < PRESSURE_ITEMS);
            r = $urandom_range(99);
            if (r < 40)
               evt.adv = 16'hFFFF;
            else if (r < 80)
               evt.adv = FIELD_BITS'($urandom_range(0, 200));
            else
               evt.adv = FIELD_BITS'($urandom_range(0, 65535));
            evt.wu = ($urandom_range(99) < 10);
            if (dup_left > 0) begin
               evt.seq = m_last_seq;
               dup_left--;
            end else begin
               r = $urandom_range(99);
               if (r < 12) begin
                  dup_left = $urandom_range(1, 6);
                  evt.seq  = m_last_seq;
               end else if (r < 35) begin
                  evt.seq = m_last_seq;
               end else if (r < 75) begin
                  evt.seq = m_last_seq + $urandom_range(1, 8);
               end else if (r < 88) begin
                  evt.seq = m_last_seq + $urandom_range(9, 3000);
               end else begin
                  evt.seq = $urandom();
               end
            end
            if ($urandom_range(99) < 6) begin
               evt.func = FUNC_TIMEOUT;
               evt.seq  = $urandom();
            end else begin
               evt.func = FUNC_ACK;
            end
            offer(evt, PREDICTED, NO_RES);
         end
      end

      drain_results(DRAIN_CYCLES);
      if (mismatches == 0)
         $display("PASS tcp_congestion_window_control");
      else
         $display("FAIL tcp_congestion_window_control");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_csr.sv
rtl/core/tcw_dpath.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcp_congestion_window_control.sv
tb/tcp_congestion_window_control_tb.sv
